// ===== src/xpds_pkg.sv =====
// Package for the XML prolog declaration scanner.
// Holds scan phase codes and byte codes; no dependencies.
`default_nettype none
package xpds_pkg;

    localparam int PHASE_W = 4;
    localparam int LINE_OUT_W = 32;

    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_START      = 4'd0;
    localparam phase_t PH_BOM1       = 4'd1;
    localparam phase_t PH_BOM2       = 4'd2;
    localparam phase_t PH_PROLOG     = 4'd3;
    localparam phase_t PH_LT         = 4'd4;
    localparam phase_t PH_LTBANG     = 4'd5;
    localparam phase_t PH_LTBANGDASH = 4'd6;
    localparam phase_t PH_CMT0       = 4'd7;
    localparam phase_t PH_CMT1       = 4'd8;
    localparam phase_t PH_CMT2       = 4'd9;
    localparam phase_t PH_PI0        = 4'd10;
    localparam phase_t PH_PI1        = 4'd11;
    localparam phase_t PH_DONE       = 4'd12;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] BOM_0    = 8'hEF;
    localparam logic [7:0] BOM_1    = 8'hBB;
    localparam logic [7:0] BOM_2    = 8'hBF;

    typedef struct packed {
        logic                  found;
        logic [LINE_OUT_W-1:0] line;
    } result_t;

endpackage
`default_nettype wire

// ===== src/xml_prolog_declaration_scan_top.sv =====
// Top level of the XML prolog declaration scanner.
// Depends on xpds_pkg.
//
// channel   dir  tdata                tuser              tlast
// s_*       in   [7:0] data_byte      -                  last_byte
// m_*       out  [31:0] decl_line     [0] declaration_found  -
//
// One byte per cycle while s_tready is high: phase, line counter and any result
// register at the accepting edge, so a result shows on m_* in the next cycle unless m_* stalls.
// Output register plus one skid entry: s_tready drops only when both hold.
// rst_n clears phase to document start, line count to 1, outputs empty.
// At most one result per document; later bytes are dropped until tlast.
`default_nettype none
module xml_prolog_declaration_scan_top
    import xpds_pkg::*;
#(
    parameter int LINE_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [LINE_OUT_W-1:0]      m_tdata,   // [31:0] decl_line
    output logic [0:0]                 m_tuser    // [0] declaration_found
);

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_SAT = {LINE_BITS{1'b1}};

    phase_t               phase_reg, phase_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 skid_valid_reg, skid_valid_next;
    result_t              skid_reg, skid_next;

    phase_t               ph_c;
    logic                 bump_c;
    logic                 emit_c;
    logic                 found_c;
    logic                 prolog_end_c;
    logic                 accept;
    logic                 pop;
    logic                 push;
    logic [LINE_OUT_W-1:0] line_out;
    result_t              res_c;

    generate
        if (LINE_BITS > LINE_OUT_W) begin : g_sat
            assign line_out = (|line_reg[LINE_BITS-1:LINE_OUT_W]) ? {LINE_OUT_W{1'b1}}
                                                                  : line_reg[LINE_OUT_W-1:0];
        end else begin : g_ext
            assign line_out = LINE_OUT_W'(line_reg);
        end
    endgenerate

    // top-level prolog byte: whitespace, newline, '<' or end of scan
    always_comb
    begin
        prolog_end_c = 1'b0;
        if (s_tdata == CH_LT) begin
            ph_c = PH_LT;
        end else if (s_tdata == CH_LF || s_tdata == CH_SP || s_tdata == CH_TAB
                     || s_tdata == CH_CR) begin
            ph_c = PH_PROLOG;
        end else begin
            ph_c = phase_reg;
            prolog_end_c = 1'b1;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bump_c     = 1'b0;
        emit_c     = 1'b0;
        found_c    = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                if (s_tdata == BOM_0) begin
                    phase_next = PH_BOM1;
                end else begin
                    phase_next = ph_c;
                    emit_c     = prolog_end_c;
                    bump_c     = (s_tdata == CH_LF);
                end
            end
            PH_BOM1:
            begin
                if (s_tdata == BOM_1) phase_next = PH_BOM2;
                else emit_c = 1'b1;
            end
            PH_BOM2:
            begin
                if (s_tdata == BOM_2) phase_next = PH_PROLOG;
                else emit_c = 1'b1;
            end
            PH_PROLOG:
            begin
                phase_next = ph_c;
                emit_c     = prolog_end_c;
                bump_c     = (s_tdata == CH_LF);
            end
            PH_LT:
            begin
                if (s_tdata == CH_BANG) phase_next = PH_LTBANG;
                else if (s_tdata == CH_QUEST) phase_next = PH_PI0;
                else emit_c = 1'b1;
            end
            PH_LTBANG:
            begin
                if (s_tdata == CH_DASH) begin
                    phase_next = PH_LTBANGDASH;
                end else begin
                    emit_c  = 1'b1;
                    found_c = 1'b1;
                end
            end
            PH_LTBANGDASH:
            begin
                if (s_tdata == CH_DASH) begin
                    phase_next = PH_CMT0;
                end else begin
                    emit_c  = 1'b1;
                    found_c = 1'b1;
                end
            end
            PH_CMT0, PH_CMT1, PH_CMT2:
            begin
                if (s_tdata == CH_DASH) begin
                    phase_next = (phase_reg == PH_CMT0) ? PH_CMT1 : PH_CMT2;
                end else if (s_tdata == CH_GT && phase_reg == PH_CMT2) begin
                    phase_next = PH_PROLOG;
                end else begin
                    bump_c     = (s_tdata == CH_LF);
                    phase_next = PH_CMT0;
                end
            end
            PH_PI0, PH_PI1:
            begin
                if (s_tdata == CH_QUEST) begin
                    phase_next = PH_PI1;
                end else if (s_tdata == CH_GT && phase_reg == PH_PI1) begin
                    phase_next = PH_PROLOG;
                end else begin
                    bump_c     = (s_tdata == CH_LF);
                    phase_next = PH_PI0;
                end
            end
            default:
            begin
                // result already given for this document
                phase_next = PH_DONE;
            end
        endcase

        // end of document forces a result unless one is already out
        if (!emit_c && s_tlast && phase_reg != PH_DONE) begin
            emit_c  = 1'b1;
            found_c = (phase_next == PH_LTBANG || phase_next == PH_LTBANGDASH);
        end
    end

    assign res_c.found = found_c;
    assign res_c.line  = found_c ? line_out : '0;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign push     = accept && emit_c;

    always_comb
    begin
        line_next = line_reg;
        if (accept) begin
            if (s_tlast) begin
                line_next = LINE_ONE;
            end else if (bump_c && line_reg != LINE_SAT) begin
                line_next = line_reg + LINE_ONE;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg) begin
            out_valid_next = push;
            out_next       = res_c;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = res_c;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = res_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_START;
            line_reg       <= LINE_ONE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_tlast) phase_reg <= PH_START;
                else if (emit_c) phase_reg <= PH_DONE;
                else phase_reg <= phase_next;
            end
            line_reg       <= line_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.line;
    assign m_tuser[0] = out_reg.found;

endmodule
`default_nettype wire

// ===== src/xpds_checker.sv =====
// Port-level checks for the XML prolog declaration scanner.
// Attached to xml_prolog_declaration_scan_top by the bind below; uses xpds_pkg.
`default_nettype none
module xpds_checker
    import xpds_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [LINE_OUT_W-1:0] m_tdata,
    input wire logic [0:0]            m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output item changed");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found item carries a line");

    a_found_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata != '0)
        else $error("found item with line zero");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("output item without an accepted input item");

endmodule

bind xml_prolog_declaration_scan_top xpds_checker u_xpds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
